// ===== design/llfq_pkg.sv =====
// Shared types, constants and helpers for the linked-list fifo with free pool.
// Used by llfq_ctrl, llfq_dp and linked_list_fifo_with_free_pool.
package llfq_pkg;

  // pool geometry
  localparam int unsigned POOL_SLOTS = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LINK_W     = $clog2(POOL_SLOTS + 1);
  localparam int unsigned SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [DATA_W-1:0] data_t;

  // link code one past the last slot means null
  localparam link_t NULL_LINK = LINK_W'(POOL_SLOTS);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // item accepted, start the store reads
    logic commit;  // update pointers and stores, register the result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

  function automatic logic is_slot(link_t l);
    return l < NULL_LINK;
  endfunction

  // after reset slot i links to i+1, the last slot links null
  function automatic link_t link_reset(slot_t s);
    return LINK_W'(s) + LINK_W'(1);
  endfunction

endpackage

// ===== design/llfq_ctrl.sv =====
// Controller for the linked-list fifo: two-state sequencer (accept, execute).
// Depends on llfq_pkg.
module llfq_ctrl import llfq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output ctrl_t    ctrl_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    ctrl_o.load   = 1'b0;
    ctrl_o.commit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      S_EXEC: begin
        ctrl_o.commit = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/llfq_dp.sv =====
// Datapath for the linked-list fifo: link and value stores, queue and free
// list pointers, output register. Depends on llfq_pkg.
module llfq_dp import llfq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ctrl_t   ctrl_i,
  output dp_stat_t stat_o,
  input  logic    command_i,
  input  data_t   push_value_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output data_t   pop_value_o,
  output logic [1:0] status_o
);

  // stores
  link_t lnk_mem [POOL_SLOTS];
  data_t val_mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] lnk_vld_q;

  // pointers
  link_t head_q, head_d;
  link_t tail_q, tail_d;
  link_t free_q, free_d;

  // captured item and read data
  cmd_e  cmd_q;
  data_t val_q;
  link_t lnk_mem_rd_q;
  logic  lnk_rd_vld_q;
  slot_t lnk_rd_slot_q;
  data_t val_rd_q;
  link_t lnk_rd;

  // output register
  logic    out_valid_q;
  data_t   pop_q, pop_d;
  status_e stat_q, stat_d;

  // store write controls
  logic  lnk_we;
  slot_t lnk_wa;
  link_t lnk_wd;
  logic  val_we;

  slot_t lnk_ra;

  assign lnk_ra = (cmd_e'(command_i) == CMD_POP) ? head_q[SLOT_W-1:0] : free_q[SLOT_W-1:0];

  // capture item and read both stores on accept
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q         <= cmd_e'(command_i);
      val_q         <= push_value_i;
      lnk_mem_rd_q  <= lnk_mem[lnk_ra];
      lnk_rd_slot_q <= lnk_ra;
      val_rd_q      <= val_mem[head_q[SLOT_W-1:0]];
    end
  end

  // link store write
  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      lnk_mem[lnk_wa] <= lnk_wd;
    end
  end

  // value store write
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[free_q[SLOT_W-1:0]] <= val_q;
    end
  end

  // per-slot written flags, unwritten links read as their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lnk_vld_q    <= '0;
      lnk_rd_vld_q <= 1'b0;
    end else begin
      if (lnk_we) lnk_vld_q[lnk_wa] <= 1'b1;
      if (ctrl_i.load) lnk_rd_vld_q <= lnk_vld_q[lnk_ra];
    end
  end

  assign lnk_rd = lnk_rd_vld_q ? lnk_mem_rd_q : link_reset(lnk_rd_slot_q);

  // execute one command
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    free_d = free_q;
    pop_d  = '0;
    stat_d = STAT_DONE;
    lnk_we = 1'b0;
    lnk_wa = tail_q[SLOT_W-1:0];
    lnk_wd = free_q;
    val_we = 1'b0;
    unique case (cmd_q)
      CMD_PUSH: begin
        if (!is_slot(free_q)) begin
          stat_d = STAT_FULL;
        end else begin
          val_we = ctrl_i.commit;
          free_d = is_slot(lnk_rd) ? lnk_rd : NULL_LINK;
          // the tail link stays stale, a pop of the tail is found by compare
          if (is_slot(tail_q)) begin
            lnk_we = ctrl_i.commit;
            lnk_wa = tail_q[SLOT_W-1:0];
            lnk_wd = free_q;
          end else begin
            head_d = free_q;
          end
          tail_d = free_q;
        end
      end
      CMD_POP: begin
        if (!is_slot(head_q)) begin
          stat_d = STAT_EMPTY;
        end else begin
          pop_d = val_rd_q;
          if (head_q == tail_q) begin
            head_d = NULL_LINK;
            tail_d = NULL_LINK;
          end else begin
            head_d = is_slot(lnk_rd) ? lnk_rd : NULL_LINK;
          end
          // return slot to the front of the free list
          lnk_we = ctrl_i.commit;
          lnk_wa = head_q[SLOT_W-1:0];
          lnk_wd = free_q;
          free_d = head_q;
        end
      end
      default: ;
    endcase
  end

  // pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= NULL_LINK;
      tail_q <= NULL_LINK;
      free_q <= '0;
    end else if (ctrl_i.commit) begin
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      pop_q  <= pop_d;
      stat_q <= stat_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign pop_value_o     = pop_q;
  assign status_o        = stat_q;

endmodule

// ===== design/linked_list_fifo_with_free_pool.sv =====
// Linked-list fifo with free pool: top level, joins llfq_ctrl and llfq_dp.
// Accept captures the item and store reads; execute registers the result,
// waiting while the output register is occupied. No new item is accepted until
// commit: the registered link store read must finish before pointers update.
// Reset: queue empty, all slots on the free list in index order; link store
// entries read as their reset link until written, no clearing pass.
module linked_list_fifo_with_free_pool import llfq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] push_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pop_value_o,
  output logic [1:0]  status_o
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  // sequencer
  llfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // stores, pointers and output register
  llfq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .command_i    (command_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o)
  );

endmodule
